// ===== rtl/tli_pkg.sv =====
// Shared types and constants for the table linear interpolator.
// Used by tli_ctrl, tli_dp and table_linear_interpolator_top; no dependencies.
`default_nettype none

package tli_pkg;

  // Table geometry
  localparam int TABLE_DEPTH = 256;
  localparam int IDX_W       = $clog2(TABLE_DEPTH);
  localparam int PC_W        = 9;

  // Divider: the quotient is known to fit in 32 bits
  localparam int DIV_STEPS   = 32;
  localparam int DIV_CNT_W   = $clog2(DIV_STEPS);

  // Operation codes
  localparam logic OP_LOAD  = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  // Region codes
  localparam logic [1:0] REGION_INSIDE = 2'd0;
  localparam logic [1:0] REGION_BELOW  = 2'd1;
  localparam logic [1:0] REGION_ABOVE  = 2'd2;

  // Table read address select
  localparam logic [1:0] RD_ZERO = 2'd0;
  localparam logic [1:0] RD_LAST = 2'd1;
  localparam logic [1:0] RD_ONE  = 2'd2;
  localparam logic [1:0] RD_NEXT = 2'd3;

  typedef struct packed {
    logic               operation;
    logic [7:0]         point_index;
    logic [31:0]        x_value;
    logic signed [31:0] y_value;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] y_result;
    logic [1:0]         region;
  } out_item_t;

  // Controller -> datapath commands
  typedef struct packed {
    logic       wr_en;      // write a table point
    logic       q_start;    // capture the query x
    logic [1:0] rd_sel;     // table read address select
    logic       prev_load;  // segment start <= table read data
    logic       seg_load;   // segment end <= table read data
    logic       idx_init;   // scan index <= 1
    logic       idx_inc;    // scan index + 1
    logic       res_lo;     // result <= first y, clamped below
    logic       res_hi;     // result <= read y, clamped above
    logic       prep;       // form dy magnitude, dx and width
    logic       mul;        // product into divider register
    logic       div_step;   // one restoring division step
    logic       fin;        // add quotient, saturate
    logic       out_load;   // result -> output register
  } cmd_t;

  // Datapath -> controller status
  typedef struct packed {
    logic below;     // query x below first x
    logic above;     // query x at or above read x
    logic hit;       // query x inside current segment
    logic scan_end;  // scan index reached last point
  } sts_t;

endpackage

`default_nettype wire

// ===== rtl/tli_ctrl.sv =====
// Sequencer for the table linear interpolator: handshakes, scan and divide control.
// Depends on tli_pkg.
`default_nettype none

module tli_ctrl (
  input  wire                 clk,
  input  wire                 rst_n,
  input  wire                 in_valid,
  input  wire                 in_op,
  output logic                in_stall,
  output logic                out_valid,
  input  wire                 out_stall,
  input  wire tli_pkg::sts_t  sts,
  output tli_pkg::cmd_t       cmd
);
  import tli_pkg::*;

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_FIRST = 4'd1;
  localparam logic [3:0] S_LAST  = 4'd2;
  localparam logic [3:0] S_SCAN  = 4'd3;
  localparam logic [3:0] S_PREP  = 4'd4;
  localparam logic [3:0] S_MUL   = 4'd5;
  localparam logic [3:0] S_DIV   = 4'd6;
  localparam logic [3:0] S_FIN   = 4'd7;
  localparam logic [3:0] S_EMIT  = 4'd8;

  logic [3:0]           state_r, state_nxt;
  logic [DIV_CNT_W-1:0] cnt_r, cnt_nxt;
  logic                 out_valid_r, out_valid_nxt;
  logic                 slot_free;

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign slot_free = !out_valid_r || !out_stall;

  // Next state and commands
  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    out_valid_nxt = out_valid_r && out_stall;
    cmd           = '0;
    cmd.rd_sel    = RD_ZERO;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          if (in_op == OP_LOAD) begin
            cmd.wr_en = 1'b1;
          end else begin
            cmd.q_start = 1'b1;
            state_nxt   = S_FIRST;
          end
        end
      end
      S_FIRST: begin
        cmd.prev_load = 1'b1;
        cmd.rd_sel    = RD_LAST;
        state_nxt     = S_LAST;
      end
      S_LAST: begin
        if (sts.below) begin
          cmd.res_lo = 1'b1;
          state_nxt  = S_EMIT;
        end else if (sts.above) begin
          cmd.res_hi = 1'b1;
          state_nxt  = S_EMIT;
        end else begin
          cmd.idx_init = 1'b1;
          cmd.rd_sel   = RD_ONE;
          state_nxt    = S_SCAN;
        end
      end
      S_SCAN: begin
        if (sts.hit) begin
          cmd.seg_load = 1'b1;
          state_nxt    = S_PREP;
        end else if (sts.scan_end) begin
          // non-ascending table with no matching segment
          cmd.res_hi = 1'b1;
          state_nxt  = S_EMIT;
        end else begin
          cmd.prev_load = 1'b1;
          cmd.idx_inc   = 1'b1;
          cmd.rd_sel    = RD_NEXT;
        end
      end
      S_PREP: begin
        cmd.prep  = 1'b1;
        state_nxt = S_MUL;
      end
      S_MUL: begin
        cmd.mul   = 1'b1;
        cnt_nxt   = '0;
        state_nxt = S_DIV;
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        cnt_nxt      = cnt_r + DIV_CNT_W'(1);
        if (cnt_r == DIV_CNT_W'(DIV_STEPS - 1)) begin
          state_nxt = S_FIN;
        end
      end
      S_FIN: begin
        cmd.fin   = 1'b1;
        state_nxt = S_EMIT;
      end
      S_EMIT: begin
        if (slot_free) begin
          cmd.out_load  = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // State registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/tli_dp.sv =====
// Datapath for the table linear interpolator: point table, scan compare,
// multiplier, restoring divider, saturation and output register. Depends on tli_pkg.
`default_nettype none

module tli_dp (
  input  wire                    clk,
  input  wire                    rst_n,
  input  wire tli_pkg::in_item_t in_item,
  input  wire                    cfg_wr_en,
  input  wire [tli_pkg::PC_W-1:0] cfg_wr_data,
  input  wire tli_pkg::cmd_t     cmd,
  output tli_pkg::sts_t          sts,
  output tli_pkg::out_item_t     out_item
);
  import tli_pkg::*;

  // Point table: {x, y} per entry, one write and one registered read
  logic [63:0]      tbl_mem [TABLE_DEPTH];
  logic [63:0]      rd_data_r;
  logic [IDX_W-1:0] rd_addr;
  logic [IDX_W-1:0] wr_addr;
  logic             wr_ok;
  logic [31:0]      rd_x;
  logic [31:0]      rd_y;

  logic [IDX_W-1:0] last_r;
  logic [IDX_W-1:0] idx_r;
  logic [31:0]      qx_r;
  logic [31:0]      prev_x_r, prev_y_r;
  logic [31:0]      seg_x_r, seg_y_r;
  logic             neg_r;
  logic [31:0]      mag_r, dx_r, wid_r;
  logic [63:0]      div_r;
  logic [31:0]      res_y_r;
  logic [1:0]       res_region_r;
  logic [31:0]      out_y_r;
  logic [1:0]       out_region_r;

  logic [31:0]      pc_ext, n_ext;
  logic [32:0]      dy, dy_neg;
  logic [63:0]      mul_p;
  logic [32:0]      div_trial, div_diff;
  logic             div_ge;
  logic [33:0]      fin_sum;
  logic [31:0]      fin_y;

  assign rd_x = rd_data_r[63:32];
  assign rd_y = rd_data_r[31:0];

  // Table write and read
  assign wr_addr = IDX_W'(in_item.point_index);
  assign wr_ok   = cmd.wr_en && (32'(in_item.point_index) < 32'(TABLE_DEPTH));

  always_comb begin
    case (cmd.rd_sel)
      RD_ZERO: rd_addr = '0;
      RD_LAST: rd_addr = last_r;
      RD_ONE:  rd_addr = IDX_W'(1);
      RD_NEXT: rd_addr = idx_r + IDX_W'(1);
      default: rd_addr = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr_ok) begin
      tbl_mem[wr_addr] <= {in_item.x_value, in_item.y_value};
    end
    rd_data_r <= tbl_mem[rd_addr];
  end

  // Point count: clamp to 1..TABLE_DEPTH, keep last index
  assign pc_ext = 32'(cfg_wr_data);
  always_comb begin
    if (pc_ext == 32'd0) begin
      n_ext = 32'd1;
    end else if (pc_ext > 32'(TABLE_DEPTH)) begin
      n_ext = 32'(TABLE_DEPTH);
    end else begin
      n_ext = pc_ext;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_r <= '0;
    end else if (cfg_wr_en) begin
      last_r <= IDX_W'(n_ext - 32'd1);
    end
  end

  // Status compares
  assign sts.below    = (qx_r < prev_x_r);
  assign sts.above    = (qx_r >= rd_x);
  assign sts.hit      = (qx_r >= prev_x_r) && (qx_r < rd_x);
  assign sts.scan_end = (idx_r == last_r);

  // Segment arithmetic
  assign dy     = {seg_y_r[31], seg_y_r} - {prev_y_r[31], prev_y_r};
  assign dy_neg = 33'd0 - dy;
  assign mul_p  = mag_r * dx_r;

  // Restoring divide step; high half stays below the width
  assign div_trial = {div_r[63:32], div_r[31]};
  assign div_diff  = div_trial - {1'b0, wid_r};
  assign div_ge    = !div_diff[32];

  // y0 +/- quotient, saturated to 32 bits
  always_comb begin
    if (neg_r) begin
      fin_sum = {{2{prev_y_r[31]}}, prev_y_r} - {2'b00, div_r[31:0]};
    end else begin
      fin_sum = {{2{prev_y_r[31]}}, prev_y_r} + {2'b00, div_r[31:0]};
    end
    if (fin_sum[33:31] == 3'b000 || fin_sum[33:31] == 3'b111) begin
      fin_y = fin_sum[31:0];
    end else if (fin_sum[33]) begin
      fin_y = 32'h8000_0000;
    end else begin
      fin_y = 32'h7FFF_FFFF;
    end
  end

  // Working registers
  always_ff @(posedge clk) begin
    if (cmd.q_start) begin
      qx_r <= in_item.x_value;
    end
    if (cmd.prev_load) begin
      prev_x_r <= rd_x;
      prev_y_r <= rd_y;
    end
    if (cmd.seg_load) begin
      seg_x_r <= rd_x;
      seg_y_r <= rd_y;
    end
    if (cmd.idx_init) begin
      idx_r <= IDX_W'(1);
    end else if (cmd.idx_inc) begin
      idx_r <= idx_r + IDX_W'(1);
    end
    if (cmd.prep) begin
      neg_r <= dy[32];
      mag_r <= dy[32] ? dy_neg[31:0] : dy[31:0];
      dx_r  <= qx_r - prev_x_r;
      wid_r <= seg_x_r - prev_x_r;
    end
    if (cmd.mul) begin
      div_r <= mul_p;
    end else if (cmd.div_step) begin
      div_r <= {(div_ge ? div_diff[31:0] : div_trial[31:0]), div_r[30:0], div_ge};
    end
    if (cmd.res_lo) begin
      res_y_r      <= prev_y_r;
      res_region_r <= REGION_BELOW;
    end else if (cmd.res_hi) begin
      res_y_r      <= rd_y;
      res_region_r <= REGION_ABOVE;
    end else if (cmd.fin) begin
      res_y_r      <= fin_y;
      res_region_r <= REGION_INSIDE;
    end
    if (cmd.out_load) begin
      out_y_r      <= res_y_r;
      out_region_r <= res_region_r;
    end
  end

  assign out_item.y_result = out_y_r;
  assign out_item.region   = out_region_r;

endmodule

`default_nettype wire

// ===== rtl/table_linear_interpolator_top.sv =====
// Top level of the table linear interpolator: sequencer plus datapath.
// Depends on tli_pkg, tli_ctrl and tli_dp.
//
// Usage:
//   Input channel (in_valid / in_stall / in_item): a load item (operation 0)
//   writes x,y at point_index and gives no result. A query item
//   (operation 1) returns one out_item with the clamped or interpolated y.
//   Config port: cfg_wr_en / cfg_wr_data writes point_count (0 acts as 1,
//   values above the table depth act as the depth). Write it while idle.
//   A query clamped below or above the table is answered after its first and
//   last points are read. A query inside it then scans for its segment,
//   reading one table point per cycle from the point memory's read port,
//   and the divider retires one quotient bit per cycle. With no matching
//   segment in a non-ascending table the scan runs to the last index and the
//   query is clamped above. Loads are taken back to back. in_stall is high
//   while a query is in flight; the next item is taken the cycle after its
//   result enters the output register. If the receiver stalls, the result
//   holds in the output register and a following query waits at its final
//   step until that register frees.
//   Reset (rst_n low, synchronous) clears control and sets point_count to 1.
`default_nettype none

module table_linear_interpolator_top (
  input  wire                     clk,
  input  wire                     rst_n,
  input  wire                     in_valid,
  output logic                    in_stall,
  input  wire tli_pkg::in_item_t  in_item,
  output logic                    out_valid,
  input  wire                     out_stall,
  output tli_pkg::out_item_t      out_item,
  input  wire                     cfg_wr_en,
  input  wire [tli_pkg::PC_W-1:0] cfg_wr_data
);
  import tli_pkg::*;

  cmd_t cmd;
  sts_t sts;

  tli_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_op     (in_item.operation),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  tli_dp u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_item     (in_item),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .cmd         (cmd),
    .sts         (sts),
    .out_item    (out_item)
  );

  // No result appears in the cycle right after an accepted transfer
  a_no_early_result: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall && !out_valid) |=> !out_valid)
    else $error("result appeared right after an input transfer");

  // A query transfer makes the block busy
  a_query_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall && in_item.operation == OP_QUERY) |=> in_stall)
    else $error("query accepted without going busy");

  // A load transfer leaves the input side free
  a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall && in_item.operation == OP_LOAD) |=> !in_stall)
    else $error("load left the input side stalled");

  // Only defined region codes are delivered
  a_region_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_item.region == REGION_INSIDE || out_item.region == REGION_BELOW ||
                   out_item.region == REGION_ABOVE))
    else $error("undefined region code on output");

endmodule

`default_nettype wire
